FILE: rtl/ofrp_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the object file record parser
package ofrp_pkg;

   localparam logic [7:0] TAG_DATA  = 8'h01;
   localparam logic [7:0] TAG_ENTRY = 8'h02;
   localparam logic [7:0] TAG_END   = 8'h03;

   localparam int unsigned HEADER_BYTES = 14;

   // byte positions inside the fixed parts
   localparam logic [3:0] HDR_MAGIC_LAST   = 4'd3;
   localparam logic [3:0] HDR_FLAGS_LAST   = 4'd7;
   localparam logic [3:0] HDR_COUNT_LAST   = 4'd11;
   localparam logic [3:0] HDR_LAST         = 4'(HEADER_BYTES - 1);
   localparam logic [3:0] DATA_SEG_POS     = 4'd1;
   localparam logic [3:0] DATA_FLAGS_LAST  = 4'd3;
   localparam logic [3:0] DATA_ADDR_LAST   = 4'd7;
   localparam logic [3:0] DATA_LAST        = 4'd11;
   localparam logic [3:0] ENTRY_ADDR_LAST  = 4'd4;
   localparam logic [3:0] ENTRY_LAST       = 4'd5;
   localparam logic [3:0] END_LAST         = 4'd4;

   typedef enum logic [2:0] {
      PH_HEADER  = 3'd0,
      PH_TAG     = 3'd1,
      PH_DATA    = 3'd2,
      PH_PAYLOAD = 3'd3,
      PH_ENTRY   = 3'd4,
      PH_END     = 3'd5,
      PH_STOP    = 3'd6
   } phase_type;

   typedef enum logic [2:0] {
      KIND_HEADER  = 3'd0,
      KIND_DATA    = 3'd1,
      KIND_PAYLOAD = 3'd2,
      KIND_ENTRY   = 3'd3,
      KIND_END     = 3'd4,
      KIND_BAD_TAG = 3'd5
   } kind_type;

   typedef struct packed {
      kind_type    record_kind;
      logic [31:0] address_or_magic;
      logic [31:0] flags_word;
      logic [31:0] byte_count;
      logic [15:0] version_info;
      logic [7:0]  segment_kind;
      logic [7:0]  payload_byte;
      logic [31:0] stored_checksum;
      logic [31:0] computed_checksum;
   } rsp_type;

endpackage

FILE: rtl/object_file_record_parser_top.sv
`timescale 1ns / 1ps
// object file record parser: header and tagged record decode, one byte per beat
//
//  channel  | direction | handshake             | payload
//  req_     | in        | req_valid / req_ready | data_byte, start_of_file
//  rsp_     | out       | rsp_valid / rsp_ready | record_kind .. computed_checksum
//  csr_     | in        | csr_write_enable      | hide_payload bit
//
// one byte accepted per cycle while req_ready is high; a result is registered in the
// output register, or in the skid entry while the output is held, at one beat a cycle.
// the rate is set by the combinational parser update feeding the output register.
// reset is synchronous and active high; it returns the parser to the header phase.
// a two-entry output buffer (output register plus skid) lets bytes flow while a
// result waits; req_ready drops only when both entries are full.
module object_file_record_parser_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_start_of_file,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output ofrp_pkg::kind_type rsp_record_kind,
   output logic [31:0] rsp_address_or_magic,
   output logic [31:0] rsp_flags_word,
   output logic [31:0] rsp_byte_count,
   output logic [15:0] rsp_version_info,
   output logic [7:0]  rsp_segment_kind,
   output logic [7:0]  rsp_payload_byte,
   output logic [31:0] rsp_stored_checksum,
   output logic [31:0] rsp_computed_checksum,
   input  logic        csr_write_enable,
   input  logic        csr_write_data
);
   import ofrp_pkg::*;

   logic        hide_ff;
   phase_type   phase_ff, phase_in, phase_eff;
   logic [3:0]  pos_ff, pos_in, pos_eff;
   logic [31:0] asm_ff, asm_in, asm_eff, asm_sh;
   logic [31:0] addr_ff, addr_in;
   logic [31:0] flags_ff, flags_in;
   logic [31:0] count_ff, count_in;
   logic [7:0]  seg_ff, seg_in;
   logic [31:0] left_ff, left_in, left_eff, left_dec;
   logic [31:0] sum_ff, sum_in, sum_eff, sum_new;

   logic        accept;
   logic        res_valid;
   rsp_type     res;
   logic        out_valid_ff, out_valid_in;
   rsp_type     out_ff, out_in;
   logic        skid_valid_ff, skid_valid_in;
   rsp_type     skid_ff, skid_in;
   logic        out_take;

   assign req_ready = !skid_valid_ff;
   assign accept    = req_valid && req_ready;
   assign out_take  = out_valid_ff && rsp_ready;

   // state as seen by this byte, after a possible restart
   always_comb begin
      if (req_start_of_file) begin
         phase_eff = PH_HEADER;
         pos_eff   = '0;
         asm_eff   = '0;
         sum_eff   = '0;
         left_eff  = '0;
      end else begin
         phase_eff = phase_ff;
         pos_eff   = pos_ff;
         asm_eff   = asm_ff;
         sum_eff   = sum_ff;
         left_eff  = left_ff;
      end
      asm_sh   = {asm_eff[23:0], req_data_byte};
      left_dec = left_eff - 32'd1;
      // checksum bytes and a stopped parse leave the sum alone
      if (phase_eff == PH_END || phase_eff == PH_STOP) begin
         sum_new = sum_eff;
      end else begin
         sum_new = sum_eff + {24'd0, req_data_byte};
      end
   end

   // next state
   always_comb begin
      phase_in = phase_eff;
      pos_in   = pos_eff + 4'd1;
      asm_in   = asm_sh;
      addr_in  = addr_ff;
      flags_in = flags_ff;
      count_in = count_ff;
      seg_in   = seg_ff;
      left_in  = left_eff;
      sum_in   = sum_new;
      case (phase_eff)
         PH_HEADER: begin
            if (pos_eff == HDR_MAGIC_LAST) addr_in = asm_sh;
            else if (pos_eff == HDR_FLAGS_LAST) flags_in = asm_sh;
            else if (pos_eff == HDR_COUNT_LAST) count_in = asm_sh;
            if (pos_eff == HDR_LAST) begin
               phase_in = PH_TAG;
               pos_in   = '0;
               asm_in   = '0;
            end
         end
         PH_TAG: begin
            asm_in = '0;
            pos_in = 4'd1;
            if (req_data_byte == TAG_DATA) phase_in = PH_DATA;
            else if (req_data_byte == TAG_ENTRY) phase_in = PH_ENTRY;
            else if (req_data_byte == TAG_END) phase_in = PH_END;
            else begin
               phase_in = PH_STOP;
               pos_in   = '0;
            end
         end
         PH_DATA: begin
            if (pos_eff == DATA_SEG_POS) seg_in = req_data_byte;
            else if (pos_eff == DATA_FLAGS_LAST) flags_in = {16'd0, asm_sh[15:0]};
            else if (pos_eff == DATA_ADDR_LAST) addr_in = asm_sh;
            if (pos_eff == DATA_LAST) begin
               count_in = asm_sh;
               left_in  = asm_sh;
               phase_in = (asm_sh == 32'd0) ? PH_TAG : PH_PAYLOAD;
               pos_in   = '0;
               asm_in   = '0;
            end
         end
         PH_PAYLOAD: begin
            asm_in  = '0;
            pos_in  = pos_eff;
            left_in = left_dec;
            if (left_dec == 32'd0) begin
               phase_in = PH_TAG;
               pos_in   = '0;
            end
         end
         PH_ENTRY: begin
            if (pos_eff == ENTRY_ADDR_LAST) addr_in = asm_sh;
            if (pos_eff == ENTRY_LAST) begin
               seg_in   = req_data_byte;
               phase_in = PH_TAG;
               pos_in   = '0;
               asm_in   = '0;
            end
         end
         PH_END: begin
            if (pos_eff == END_LAST) begin
               phase_in = PH_STOP;
               pos_in   = '0;
               asm_in   = '0;
            end
         end
         default: begin
            asm_in = '0;
            pos_in = pos_eff;
         end
      endcase
   end

   // result for this byte
   always_comb begin
      res       = '0;
      res_valid = 1'b0;
      case (phase_eff)
         PH_HEADER: begin
            if (pos_eff == HDR_LAST) begin
               res_valid            = 1'b1;
               res.record_kind      = KIND_HEADER;
               res.address_or_magic = addr_ff;
               res.flags_word       = flags_ff;
               res.byte_count       = count_ff;
               res.version_info     = asm_sh[15:0];
            end
         end
         PH_TAG: begin
            if (req_data_byte != TAG_DATA && req_data_byte != TAG_ENTRY &&
                req_data_byte != TAG_END) begin
               res_valid        = 1'b1;
               res.record_kind  = KIND_BAD_TAG;
               res.payload_byte = req_data_byte;
            end
         end
         PH_DATA: begin
            if (pos_eff == DATA_LAST) begin
               res_valid            = 1'b1;
               res.record_kind      = KIND_DATA;
               res.address_or_magic = addr_ff;
               res.flags_word       = flags_ff;
               res.byte_count       = asm_sh;
               res.segment_kind     = seg_ff;
            end
         end
         PH_PAYLOAD: begin
            if (!hide_ff) begin
               res_valid        = 1'b1;
               res.record_kind  = KIND_PAYLOAD;
               res.payload_byte = req_data_byte;
            end
         end
         PH_ENTRY: begin
            if (pos_eff == ENTRY_LAST) begin
               res_valid            = 1'b1;
               res.record_kind      = KIND_ENTRY;
               res.address_or_magic = addr_ff;
               res.segment_kind     = req_data_byte;
            end
         end
         PH_END: begin
            if (pos_eff == END_LAST) begin
               res_valid             = 1'b1;
               res.record_kind       = KIND_END;
               res.stored_checksum   = asm_sh;
               res.computed_checksum = 32'd0 - sum_new;
            end
         end
         default: begin
            res_valid = 1'b0;
         end
      endcase
   end

   // output register with skid entry behind it
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (out_take) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = 1'b0;
         end
      end
      if (accept && res_valid) begin
         if (!out_valid_ff || out_take) begin
            out_in       = res;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = res;
            skid_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hide_ff       <= 1'b0;
         phase_ff      <= PH_HEADER;
         pos_ff        <= '0;
         asm_ff        <= '0;
         addr_ff       <= '0;
         flags_ff      <= '0;
         count_ff      <= '0;
         seg_ff        <= '0;
         left_ff       <= '0;
         sum_ff        <= '0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) hide_ff <= csr_write_data;
         if (accept) begin
            phase_ff <= phase_in;
            pos_ff   <= pos_in;
            asm_ff   <= asm_in;
            addr_ff  <= addr_in;
            flags_ff <= flags_in;
            count_ff <= count_in;
            seg_ff   <= seg_in;
            left_ff  <= left_in;
            sum_ff   <= sum_in;
         end
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid             = out_valid_ff;
   assign rsp_record_kind       = out_ff.record_kind;
   assign rsp_address_or_magic  = out_ff.address_or_magic;
   assign rsp_flags_word        = out_ff.flags_word;
   assign rsp_byte_count        = out_ff.byte_count;
   assign rsp_version_info      = out_ff.version_info;
   assign rsp_segment_kind      = out_ff.segment_kind;
   assign rsp_payload_byte      = out_ff.payload_byte;
   assign rsp_stored_checksum   = out_ff.stored_checksum;
   assign rsp_computed_checksum = out_ff.computed_checksum;

   // skid entry only fills behind a held output beat
   assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry valid with empty output register");

   // a start beat always leaves the parser on header byte one
   assert property (@(posedge clock) disable iff (reset)
      (accept && req_start_of_file) |=> (phase_ff == PH_HEADER && pos_ff == 4'd1))
      else $error("restart did not land on header byte one");

   // a stopped parse ignores bytes until a restart
   assert property (@(posedge clock) disable iff (reset)
      (accept && !req_start_of_file && phase_ff == PH_STOP)
      |=> (phase_ff == PH_STOP && $stable(sum_ff)))
      else $error("stopped parser changed state");

   // payload phase always has bytes still to come
   assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_PAYLOAD) |-> (left_ff != 32'd0))
      else $error("payload phase with zero bytes left");

   // checksum fields belong to end beats only
   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.record_kind != KIND_END)
      |-> (out_ff.computed_checksum == 32'd0 && out_ff.stored_checksum == 32'd0))
      else $error("checksum on a non-end beat");

endmodule
